// ===== src/mrfc_pkg.sv =====
package mrfc_pkg;

	localparam logic [15:0] CrcPoly   = 16'hA001;
	localparam logic [15:0] CrcInit   = 16'hFFFF;
	localparam logic [7:0]  AddrReset = 8'h01;

	// frame byte positions
	localparam logic [2:0] PosIdle   = 3'd0;
	localparam logic [2:0] PosRdHigh = 3'd3;
	localparam logic [2:0] PosRdLow  = 3'd4;
	localparam logic [2:0] PosCrcLow = 3'd5;
	localparam logic [2:0] PosLast   = 3'd6;
	localparam logic [2:0] PosStray  = 3'd7;

	typedef struct packed {
		logic        last;
		logic [15:0] reading;
		logic        crc_good;
	} frame_res_t;

	// one byte of reflected crc-16, lsb first
	function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
		logic [15:0] c;
		c = crc_in ^ {8'h00, b};
		for (int i = 0; i < 8; i++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CrcPoly;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

// ===== src/modbus_reply_frame_checker.sv =====
// Modbus RTU reply checker: takes one received byte per word on the input
// channel and accepts a word every cycle unless the input stalls. While idle,
// bytes are dropped until one equals slave_address (reset 1); that byte opens
// a 7-byte frame in which every byte is data. The CRC-16/MODBUS over bytes
// 0..4 is updated one byte per cycle and compared with bytes 5 (low) and 6
// (high). The seventh byte yields one result word (reading = bytes 3:4,
// crc_good). That byte passes the input register, and its result word is then
// written to an output register, where it is held until taken. Input stalls
// only when a finished frame waits in the input register behind a full output.
// slave_address may be written only while no frame is in progress.
module modbus_reply_frame_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        slave_address_we,
	input  logic [7:0]  slave_address,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] reading,
	output logic        crc_good
);
	import mrfc_pkg::*;

	logic        addr_we_dummy;
	logic [7:0]  addr_q;
	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        advance;
	frame_res_t  res;
	logic        out_valid_q;
	logic [15:0] reading_q;
	logic        crc_good_q;

	assign addr_we_dummy = slave_address_we;

	// last byte of a frame waits while the output still holds an untaken word
	assign advance  = valid_s1 && (!res.last || !out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q <= AddrReset;
		end else if (addr_we_dummy) begin
			addr_q <= slave_address;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= rx_byte;
		end
	end

	mrfc_frame u_frame (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (advance),
		.rx_byte       (byte_s1),
		.slave_address (addr_q),
		.res           (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && res.last) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res.last) begin
			reading_q  <= res.reading;
			crc_good_q <= res.crc_good;
		end
	end

	assign out_valid = out_valid_q;
	assign reading   = reading_q;
	assign crc_good  = crc_good_q;

endmodule

// ===== src/mrfc_frame.sv =====
module mrfc_frame (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  step,
	input  logic [7:0]            rx_byte,
	input  logic [7:0]            slave_address,
	output mrfc_pkg::frame_res_t  res
);
	import mrfc_pkg::*;

	logic [2:0]  count_q;
	logic [15:0] crc_q;
	logic [15:0] reading_q;
	logic [7:0]  crc_low_q;
	logic        idle;
	logic [15:0] crc_next;

	assign idle     = (count_q == PosIdle) || (count_q == PosStray);
	// frame start reloads the init value
	assign crc_next = crc_byte(idle ? CrcInit : crc_q, rx_byte);

	assign res.last     = (count_q == PosLast);
	assign res.reading  = reading_q;
	assign res.crc_good = ({rx_byte, crc_low_q} == crc_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= PosIdle;
			crc_q   <= CrcInit;
		end else if (step) begin
			if (idle) begin
				if (rx_byte == slave_address) begin
					count_q <= 3'd1;
					crc_q   <= crc_next;
				end else begin
					count_q <= PosIdle;
				end
			end else if (count_q < PosCrcLow) begin
				count_q <= count_q + 3'd1;
				crc_q   <= crc_next;
			end else if (count_q == PosCrcLow) begin
				count_q <= count_q + 3'd1;
			end else begin
				count_q <= PosIdle;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			if (count_q == PosRdHigh) begin
				reading_q[15:8] <= rx_byte;
			end
			if (count_q == PosRdLow) begin
				reading_q[7:0] <= rx_byte;
			end
			if (count_q == PosCrcLow) begin
				crc_low_q <= rx_byte;
			end
		end
	end

endmodule

// ===== src/mrfc_checker.sv =====
module mrfc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [15:0] reading,
	input logic        crc_good
);

	// a waiting result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(reading) && $stable(crc_good))
		else $error("result word changed while stalled");

	// input backpressure only comes from a blocked output
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input stalled without a blocked output");

	// a new result word is preceded by an accepted byte
	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready, 2))
		else $error("result word without a preceding byte");

endmodule

bind modbus_reply_frame_checker mrfc_checker u_mrfc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.reading   (reading),
	.crc_good  (crc_good)
);
